### src/reb_pkg.sv
package reb_pkg;

	typedef enum logic [2:0] {
		EV_NONE  = 3'd0,
		EV_CW    = 3'd1,
		EV_CCW   = 3'd2,
		EV_CLICK = 3'd3,
		EV_LONG  = 3'd4,
		EV_SUPER = 3'd5
	} evt_t;

	typedef enum logic [1:0] {
		REG_STEPS_PER_DETENT = 2'd0,
		REG_DEBOUNCE_TICKS   = 2'd1,
		REG_LONG_PRESS_TICKS = 2'd2,
		REG_SUPER_LONG_TICKS = 2'd3
	} reg_idx_t;

	localparam int CFG_DATA_W = 16;

	typedef struct packed {
		logic [3:0]  steps_per_detent;
		logic [7:0]  debounce_ticks;
		logic [15:0] long_press_ticks;
		logic [15:0] super_long_ticks;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		steps_per_detent: 4'd4,
		debounce_ticks:   8'd20,
		long_press_ticks: 16'd3000,
		super_long_ticks: 16'd10000
	};

endpackage

### src/rotary_encoder_button_events.sv
// Rotary encoder and push-button event block.
//
// Input channel (in_valid / in_stall): one beat per item. operation = 0 is a
// sample tick carrying pin_a, pin_b and button_level (active low); it yields
// no result. operation = 1 reads the pending event and clears it; its pin
// fields are ignored.
// Output channel (out_valid / out_stall): one beat per read, event_code
// 0 none, 1 cw, 2 ccw, 3 click, 4 long press, 5 super long press.
// An accepted beat is held in the input register and processed from there; a
// read result is then captured in the output register. Throughput is one beat
// per cycle while no read is blocked behind a stalled result, set by the
// single pass of decode and debounce logic between the input and result registers.
// A stalled result holds in the output register; ticks keep flowing, and a
// read behind it waits in the input register, raising in_stall.
// Configuration: cfg_we with cfg_index and cfg_data, written while idle.
// Reset: registers return to 4 / 20 / 3000 / 10000, phase to both pins high,
// button to released, pending event to none.
module rotary_encoder_button_events
	import reb_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  operation,
	input  logic                  pin_a,
	input  logic                  pin_b,
	input  logic                  button_level,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [2:0]            event_code
);

	cfg_t       cfg_q;
	logic       valid_s1;
	logic       op_s1;
	logic [1:0] phase_s1;
	logic       btn_s1;
	evt_t       pending_q;
	logic       out_valid_q;
	evt_t       event_q;

	logic       out_free;
	logic       go;
	logic       tick_go;
	logic       rd_go;
	evt_t       rot_ev;
	evt_t       btn_ev;
	evt_t       tick_ev;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_STEPS_PER_DETENT: cfg_q.steps_per_detent <= cfg_data[3:0];
				REG_DEBOUNCE_TICKS:   cfg_q.debounce_ticks   <= cfg_data[7:0];
				REG_LONG_PRESS_TICKS: cfg_q.long_press_ticks <= cfg_data[15:0];
				REG_SUPER_LONG_TICKS: cfg_q.super_long_ticks <= cfg_data[15:0];
				default:              cfg_q                  <= cfg_q;
			endcase
		end
	end

	assign out_free = !out_valid_q || !out_stall;
	assign go       = valid_s1 && (!op_s1 || out_free);
	assign tick_go  = valid_s1 && !op_s1;
	assign rd_go    = valid_s1 && op_s1 && out_free;
	assign in_stall = valid_s1 && !go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_s1    <= operation;
			phase_s1 <= {pin_b, pin_a};
			btn_s1   <= button_level;
		end
	end

	reb_encoder u_encoder (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (tick_go),
		.phase  (phase_s1),
		.cfg    (cfg_q),
		.rot_ev (rot_ev)
	);

	reb_button u_button (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (tick_go),
		.pin    (btn_s1),
		.cfg    (cfg_q),
		.btn_ev (btn_ev)
	);

	assign tick_ev = (btn_ev != EV_NONE) ? btn_ev : rot_ev;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= EV_NONE;
		end else if (rd_go) begin
			pending_q <= EV_NONE;
		end else if (tick_go && (tick_ev != EV_NONE)) begin
			pending_q <= tick_ev;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rd_go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_go) begin
			event_q <= pending_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign event_code = event_q;

	a_read_result: assert property (@(posedge clk) disable iff (!arst_n)
		rd_go |=> out_valid && (event_code == $past(pending_q)))
		else $error("read did not deliver the pending event");

	a_read_clears: assert property (@(posedge clk) disable iff (!arst_n)
		rd_go |=> pending_q == EV_NONE)
		else $error("pending event not cleared by read");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && op_s1 && out_valid_q && out_stall)
		else $error("input stalled without a blocked read");

endmodule

### src/reb_encoder.sv
module reb_encoder
	import reb_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic [1:0] phase,
	input  cfg_t       cfg,
	output evt_t       rot_ev
);

	logic [1:0]        last_phase_q;
	logic signed [4:0] acc_q;
	logic signed [4:0] acc_step;
	logic signed [4:0] acc_d;
	logic signed [4:0] limit;
	logic [3:0]        trans;

	always_comb begin
		trans    = {last_phase_q, phase};
		acc_step = acc_q;
		case (trans) inside
			4'd13, 4'd4, 4'd2, 4'd11: acc_step = acc_q + 5'sd1;
			4'd14, 4'd7, 4'd1, 4'd8:  acc_step = acc_q - 5'sd1;
			default:                  acc_step = acc_q;
		endcase
		limit = (cfg.steps_per_detent == 4'd0) ? 5'sd1 : $signed({1'b0, cfg.steps_per_detent});
		rot_ev = EV_NONE;
		acc_d  = acc_step;
		if (acc_step >= limit) begin
			rot_ev = EV_CW;
			acc_d  = 5'sd0;
		end else if (acc_step <= -limit) begin
			rot_ev = EV_CCW;
			acc_d  = 5'sd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_phase_q <= 2'd3;
			acc_q        <= 5'sd0;
		end else if (en) begin
			last_phase_q <= phase;
			acc_q        <= acc_d;
		end
	end

	a_acc_range: assert property (@(posedge clk) disable iff (!arst_n)
		(acc_q >= -5'sd14) && (acc_q <= 5'sd14))
		else $error("step accumulator out of range");

	a_rot_clears: assert property (@(posedge clk) disable iff (!arst_n)
		en && (rot_ev != EV_NONE) |=> acc_q == 5'sd0)
		else $error("accumulator not cleared after rotation");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(acc_q) && $stable(last_phase_q))
		else $error("encoder state moved without a tick");

endmodule

### src/reb_button.sv
module reb_button
	import reb_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic pin,
	input  cfg_t cfg,
	output evt_t btn_ev
);

	logic        stable_q;
	logic [7:0]  cnt_q;
	logic [15:0] press_q;
	logic        long_q;
	logic        super_q;

	logic        stable_d;
	logic [7:0]  cnt_d;
	logic [15:0] press_d;
	logic        long_d;
	logic        super_d;

	always_comb begin
		stable_d = stable_q;
		press_d  = press_q;
		long_d   = long_q;
		super_d  = super_q;
		btn_ev   = EV_NONE;
		if (pin == stable_q) begin
			cnt_d = 8'd0;
		end else if (cnt_q != 8'hFF) begin
			cnt_d = cnt_q + 8'd1;
		end else begin
			cnt_d = cnt_q;
		end
		if (cnt_d >= cfg.debounce_ticks) begin
			if (stable_q && !pin) begin
				press_d = 16'd0;
				long_d  = 1'b0;
				super_d = 1'b0;
			end else if (!stable_q && pin && !long_q) begin
				btn_ev = EV_CLICK;
			end
			stable_d = pin;
			cnt_d    = 8'd0;
		end
		if (!stable_d) begin
			if (!super_d && (press_d > cfg.super_long_ticks)) begin
				btn_ev  = EV_SUPER;
				super_d = 1'b1;
				long_d  = 1'b1;
			end else if (!long_d && (press_d > cfg.long_press_ticks)) begin
				btn_ev = EV_LONG;
				long_d = 1'b1;
			end
			if (press_d != 16'hFFFF) begin
				press_d = press_d + 16'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_q <= 1'b1;
			cnt_q    <= 8'd0;
			press_q  <= 16'd0;
			long_q   <= 1'b0;
			super_q  <= 1'b0;
		end else if (en) begin
			stable_q <= stable_d;
			cnt_q    <= cnt_d;
			press_q  <= press_d;
			long_q   <= long_d;
			super_q  <= super_d;
		end
	end

	a_super_implies_long: assert property (@(posedge clk) disable iff (!arst_n)
		super_q |-> long_q)
		else $error("super long reported without long");

	a_press_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		en && !stable_d && (press_q == 16'hFFFF) && (stable_q == stable_d) |=> press_q == 16'hFFFF)
		else $error("press counter wrapped");

	a_click_on_release: assert property (@(posedge clk) disable iff (!arst_n)
		(btn_ev == EV_CLICK) |-> !stable_q && pin && !long_q)
		else $error("click without a release");

endmodule
